/* hw/rtl/fixed_text_console_engine_macros.svh */
// Assertion macros for the console engine.
`ifndef FIXED_TEXT_CONSOLE_ENGINE_MACROS_SVH
`define FIXED_TEXT_CONSOLE_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside reset.
`define FTCE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define FTCE_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define FTCE_ASSERT(label, clk, rst_n, prop, msg)
`define FTCE_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

/* hw/rtl/ftce_pkg.sv */
package ftce_pkg;

    // Default screen geometry.
    localparam int DEF_COLUMNS = 64;
    localparam int DEF_ROWS    = 32;

    // Field widths of the item ports.
    localparam int DATA_W     = 32;
    localparam int CODE_W     = 8;
    localparam int ADDR_IN_W  = 11;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 6;
    localparam int POS_OUT_W  = 11;

    // Item kinds.
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_READ = 1'b1;

    // Character and control codes.
    localparam logic [CODE_W-1:0] C_BS    = 8'h08;
    localparam logic [CODE_W-1:0] C_TAB   = 8'h09;
    localparam logic [CODE_W-1:0] C_LF    = 8'h0A;
    localparam logic [CODE_W-1:0] C_FF    = 8'h0C;
    localparam logic [CODE_W-1:0] C_CR    = 8'h0D;
    localparam logic [CODE_W-1:0] C_BLANK = 8'h20;
    localparam logic [CODE_W-1:0] C_UP    = 8'h90;
    localparam logic [CODE_W-1:0] C_RIGHT = 8'h91;
    localparam logic [CODE_W-1:0] C_DOWN  = 8'h92;
    localparam logic [CODE_W-1:0] C_LEFT  = 8'h93;
    localparam logic [CODE_W-1:0] C_HOME  = 8'h94;
    localparam logic [CODE_W-1:0] C_DEL   = 8'h99;

    // A tab expands into this many blanks.
    localparam int TAB_PUTS = 4;
    localparam int REP_W    = $clog2(TAB_PUTS);

endpackage

/* hw/rtl/fixed_text_console_engine.sv */
// Text console over a ROWS x COLUMNS screen of 32-bit cells held in one RAM with
// a single write and a single registered read port. Delete and backspace sweep
// the rest of the row through the RAM, one cell a cycle. A scroll (line feed or
// wrap at the bottom row) and a clear sweep the whole screen. After reset a
// clearing pass zeroes the screen while the input stalls; attribute writes are
// taken at any time and should only be made while the engine is idle. Each item
// gives one result, held in an output register so the next item can start while
// the result waits to be taken.
`include "fixed_text_console_engine_macros.svh"

module fixed_text_console_engine
    import ftce_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_kind,
    input  logic [CODE_W-1:0]    i_char_code,
    input  logic [ADDR_IN_W-1:0] i_cell_address,

    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DATA_W-1:0]    o_read_data,
    output logic [ROW_OUT_W-1:0] o_cursor_row,
    output logic [COL_OUT_W-1:0] o_cursor_col,
    output logic [POS_OUT_W-1:0] o_cursor_position,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int XW    = ((AW > ADDR_IN_W) ? AW : ADDR_IN_W) + 1;
    localparam int PW    = (AW > POS_OUT_W) ? AW : POS_OUT_W;
    localparam int RXW   = (RW > ROW_OUT_W) ? RW : ROW_OUT_W;
    localparam int CXW   = (CW > COL_OUT_W) ? CW : COL_OUT_W;

    localparam logic [RW-1:0] ROW_LAST   = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST   = CW'(COLUMNS - 1);
    localparam logic [AW-1:0] CELL_LAST  = AW'(CELLS - 1);
    localparam logic [AW-1:0] SCROLL_LIM = AW'(CELLS - COLUMNS);

    typedef enum logic [7:0] {
        S_SWEEP = 8'b0000_0001,
        S_FLUSH = 8'b0000_0010,
        S_IDLE  = 8'b0000_0100,
        S_PUT   = 8'b0000_1000,
        S_DEL   = 8'b0001_0000,
        S_READ  = 8'b0010_0000,
        S_RDATA = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    t_state r_ret, n_ret;

    // Sweep engine: walks r_ptr to r_end, copying from r_ptr plus an offset
    // while below r_lim and writing blanks after that.
    logic [AW-1:0] r_ptr, n_ptr;
    logic [AW-1:0] r_end, n_end;
    logic [AW-1:0] r_lim, n_lim;
    logic          r_far, n_far;
    logic          r_zero, n_zero;
    logic          r_wr_valid, n_wr_valid;
    logic [AW-1:0] r_wr_addr, n_wr_addr;
    logic          r_wr_copy, n_wr_copy;

    logic [RW-1:0]      r_row, n_row;
    logic [CW-1:0]      r_col, n_col;
    logic [REP_W-1:0]   r_rep, n_rep;
    logic [CODE_W-1:0]  r_code, n_code;
    logic [AW-1:0]      r_addr, n_addr;
    logic               r_in_range, n_in_range;
    logic [DATA_W-1:0]  r_res_data, n_res_data;
    logic [DATA_W-1:0]  r_attr;

    logic                 r_out_valid, n_out_valid;
    logic [DATA_W-1:0]    r_out_data, n_out_data;
    logic [ROW_OUT_W-1:0] r_out_row, n_out_row;
    logic [COL_OUT_W-1:0] r_out_col, n_out_col;
    logic [POS_OUT_W-1:0] r_out_pos, n_out_pos;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic [AW-1:0]     row_base;
    logic [AW-1:0]     cur_addr;
    logic [AW-1:0]     sweep_off;
    logic [DATA_W-1:0] blank;
    logic [XW-1:0]     addr_ext;
    logic [PW-1:0]     pos_ext;
    logic [RXW-1:0]    row_ext;
    logic [CXW-1:0]    col_ext;
    logic              out_free;
    logic              accept;
    logic              go_scroll;
    logic              go_clear;

    assign row_base  = AW'(r_row) * AW'(COLUMNS);
    assign cur_addr  = row_base + AW'(r_col);
    assign sweep_off = r_far ? AW'(COLUMNS) : AW'(1);
    assign blank     = r_zero ? '0 : (r_attr | DATA_W'(C_BLANK));
    assign addr_ext  = XW'(i_cell_address);
    assign pos_ext   = PW'(cur_addr);
    assign row_ext   = RXW'(r_row);
    assign col_ext   = CXW'(r_col);

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) || ((r_state == S_DONE) && out_free));
    assign accept     = i_in_valid && !o_in_stall;

    // A pending sweep write owns the port; character writes happen only in S_PUT,
    // which is never entered while one is pending.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = r_attr | DATA_W'(r_code);
        if (r_wr_valid) begin
            mem_we    = 1'b1;
            mem_waddr = r_wr_addr;
            mem_wdata = r_wr_copy ? mem_rdata : blank;
        end else if (r_state == S_PUT) begin
            mem_we = 1'b1;
        end
    end

    assign mem_raddr = (r_state == S_SWEEP) ? (r_ptr + sweep_off) : r_addr;

    ftce_screen #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_ret       = r_ret;
        n_ptr       = r_ptr;
        n_end       = r_end;
        n_lim       = r_lim;
        n_far       = r_far;
        n_zero      = r_zero;
        n_wr_valid  = 1'b0;
        n_wr_addr   = r_ptr;
        n_wr_copy   = 1'b0;
        n_row       = r_row;
        n_col       = r_col;
        n_rep       = r_rep;
        n_code      = r_code;
        n_addr      = r_addr;
        n_in_range  = r_in_range;
        n_res_data  = r_res_data;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_pos   = r_out_pos;
        go_scroll   = 1'b0;
        go_clear    = 1'b0;

        case (r_state)
            S_SWEEP: begin
                n_wr_valid = 1'b1;
                n_wr_copy  = (r_ptr < r_lim);
                if (r_ptr == r_end) begin
                    n_state = S_FLUSH;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            S_FLUSH: begin
                n_state = r_ret;
            end
            S_IDLE: begin
            end
            S_PUT: begin
                if (r_col == COL_LAST) begin
                    n_col = '0;
                    if (r_row < ROW_LAST) begin
                        n_row = r_row + RW'(1);
                    end else begin
                        go_scroll = 1'b1;
                    end
                end else begin
                    n_col = r_col + CW'(1);
                end
                if (r_rep == '0) begin
                    n_state = S_DONE;
                    n_ret   = S_DONE;
                end else begin
                    n_rep = r_rep - REP_W'(1);
                    n_ret = S_PUT;
                end
            end
            S_DEL: begin
                n_ptr   = cur_addr;
                n_end   = row_base + AW'(COLUMNS - 1);
                n_lim   = row_base + AW'(COLUMNS - 1);
                n_far   = 1'b0;
                n_zero  = 1'b0;
                n_ret   = S_DONE;
                n_state = S_SWEEP;
            end
            S_READ: begin
                n_state = S_RDATA;
            end
            S_RDATA: begin
                n_res_data = r_in_range ? mem_rdata : '0;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res_data;
                    n_out_row   = row_ext[ROW_OUT_W-1:0];
                    n_out_col   = col_ext[COL_OUT_W-1:0];
                    n_out_pos   = pos_ext[POS_OUT_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (accept) begin
            n_code     = i_char_code;
            n_rep      = '0;
            n_res_data = '0;
            n_ret      = S_DONE;
            n_state    = S_DONE;
            if (i_kind == KIND_READ) begin
                n_addr     = addr_ext[AW-1:0];
                n_in_range = (addr_ext < XW'(CELLS));
                n_state    = S_READ;
            end else begin
                case (i_char_code)
                    C_CR: begin
                        n_col = '0;
                    end
                    C_LF: begin
                        if (r_row < ROW_LAST) begin
                            n_row = r_row + RW'(1);
                        end else begin
                            go_scroll = 1'b1;
                        end
                    end
                    C_RIGHT: begin
                        if (r_col < COL_LAST) begin
                            n_col = r_col + CW'(1);
                        end
                    end
                    C_UP: begin
                        if (r_row != '0) begin
                            n_row = r_row - RW'(1);
                        end
                    end
                    C_LEFT: begin
                        if (r_col != '0) begin
                            n_col = r_col - CW'(1);
                        end
                    end
                    C_DOWN: begin
                        if (r_row < ROW_LAST) begin
                            n_row = r_row + RW'(1);
                        end
                    end
                    C_HOME: begin
                        if (r_col == '0) begin
                            n_row = '0;
                        end
                        n_col = '0;
                    end
                    C_DEL: begin
                        n_state = S_DEL;
                    end
                    C_BS: begin
                        if (r_col != '0) begin
                            n_col   = r_col - CW'(1);
                            n_state = S_DEL;
                        end
                    end
                    C_FF: begin
                        n_row    = '0;
                        n_col    = '0;
                        go_clear = 1'b1;
                    end
                    C_TAB: begin
                        n_code  = C_BLANK;
                        n_rep   = REP_W'(TAB_PUTS - 1);
                        n_state = S_PUT;
                    end
                    default: begin
                        n_state = S_PUT;
                    end
                endcase
            end
        end

        if (go_scroll || go_clear) begin
            n_ptr   = '0;
            n_end   = CELL_LAST;
            n_lim   = go_scroll ? SCROLL_LIM : '0;
            n_far   = 1'b1;
            n_zero  = 1'b0;
            n_state = S_SWEEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // The clearing pass after reset is a zero-fill sweep.
            r_state     <= S_SWEEP;
            r_ret       <= S_IDLE;
            r_ptr       <= '0;
            r_end       <= CELL_LAST;
            r_lim       <= '0;
            r_far       <= 1'b1;
            r_zero      <= 1'b1;
            r_wr_valid  <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_rep       <= '0;
            r_out_valid <= 1'b0;
            r_attr      <= '0;
        end else begin
            r_state     <= n_state;
            r_ret       <= n_ret;
            r_ptr       <= n_ptr;
            r_end       <= n_end;
            r_lim       <= n_lim;
            r_far       <= n_far;
            r_zero      <= n_zero;
            r_wr_valid  <= n_wr_valid;
            r_row       <= n_row;
            r_col       <= n_col;
            r_rep       <= n_rep;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr  <= n_wr_addr;
        r_wr_copy  <= n_wr_copy;
        r_code     <= n_code;
        r_addr     <= n_addr;
        r_in_range <= n_in_range;
        r_res_data <= n_res_data;
        r_out_data <= n_out_data;
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_pos  <= n_out_pos;
    end

    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_read_data       = r_out_data;
    assign o_cursor_row      = r_out_row;
    assign o_cursor_col      = r_out_col;
    assign o_cursor_position = r_out_pos;

    `FTCE_ASSERT(a_accept_only_when_free, i_clk, i_rst_n, (!o_in_stall) |-> ((r_state == S_IDLE) || (r_state == S_DONE)), "item accepted while engine busy")
    `FTCE_ASSERT(a_no_write_clash, i_clk, i_rst_n, r_wr_valid |-> (r_state != S_PUT), "sweep write pending during character write")
    `FTCE_ASSERT(a_cursor_in_screen, i_clk, i_rst_n, (r_row <= ROW_LAST) && (r_col <= COL_LAST), "cursor outside screen")
    `FTCE_ASSERT(a_sweep_bounded, i_clk, i_rst_n, (r_state == S_SWEEP) |-> (r_ptr <= r_end), "sweep pointer past its end")
    `FTCE_ASSERT(a_char_gives_zero_data, i_clk, i_rst_n, (accept && (i_kind == KIND_CHAR)) |=> (r_res_data == '0), "character item carries read data")

endmodule

/* hw/rtl/ftce_screen.sv */
module ftce_screen
    import ftce_pkg::*;
#(
    parameter int DEPTH = DEF_ROWS * DEF_COLUMNS,
    parameter int AW    = $clog2(DEF_ROWS * DEF_COLUMNS)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
